### rtl/hvtic_pkg.sv
// Shared types and constants for the HV timer and interrupt controller.
`default_nettype none
package hvtic_pkg;

    localparam int LINE_CLOCKS = 1364;

    localparam int H_W      = 11;
    localparam int V_W      = 9;
    localparam int CMP_W    = 9;
    localparam int LCNT_W   = 10;
    localparam int VEC_W    = 16;
    localparam int FLAG_W   = 4;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;
    localparam int IN_DW    = 8;
    localparam int OUT_DW   = 48;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_BOUNDARY = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_SERVICED = 2'd3
    } t_cmd;

    typedef enum logic [CFG_AW-1:0] {
        REG_LINEAR_MODE = 3'd0,
        REG_CMP_EN      = 3'd1,
        REG_H_CMP       = 3'd2,
        REG_V_CMP       = 3'd3,
        REG_LINE_COUNT  = 3'd4,
        REG_NMI_VECTOR  = 3'd5,
        REG_IRQ_VECTOR  = 3'd6,
        REG_IRQ_EN      = 3'd7
    } t_reg;

    localparam logic [FLAG_W-1:0] FLAG_NMI   = 4'b0001;
    localparam logic [FLAG_W-1:0] FLAG_TIMER = 4'b0010;
    localparam logic [FLAG_W-1:0] FLAG_DMA   = 4'b0100;
    localparam logic [FLAG_W-1:0] FLAG_IRQ   = 4'b1000;
    localparam logic [FLAG_W-1:0] FLAG_NONE  = 4'b0000;

    localparam int IEN_TIMER = 0;
    localparam int IEN_DMA   = 1;

    localparam logic [1:0] CMPEN_OFF  = 2'd0;
    localparam logic [1:0] CMPEN_H    = 2'd1;
    localparam logic [1:0] CMPEN_V    = 2'd2;
    localparam logic [1:0] CMPEN_HV   = 2'd3;

    localparam logic [LCNT_W-1:0] LINE_COUNT_RST = 10'd262;

    typedef struct packed {
        logic [H_W-1:0] h;
        logic [V_W-1:0] v;
        logic           hit;
    } t_tick;

    typedef struct packed {
        logic              take;
        logic [FLAG_W-1:0] flag;
        logic [VEC_W-1:0]  vec;
        logic [FLAG_W-1:0] mark_set;
    } t_pick;

endpackage
`default_nettype wire

### rtl/hvtic_tick.sv
// Counter advance and compare match for one timer tick.
`default_nettype none
module hvtic_tick (
    input  wire logic                        i_linear_mode,
    input  wire logic [1:0]                  i_cmp_en,
    input  wire logic [hvtic_pkg::CMP_W-1:0] i_h_cmp,
    input  wire logic [hvtic_pkg::CMP_W-1:0] i_v_cmp,
    input  wire logic [hvtic_pkg::LCNT_W-1:0] i_line_count,
    input  wire logic [hvtic_pkg::H_W-1:0]   i_h,
    input  wire logic [hvtic_pkg::V_W-1:0]   i_v,
    output hvtic_pkg::t_tick                 o_tick
);
    import hvtic_pkg::*;

    logic [H_W:0]    h_sum;
    logic [LCNT_W-1:0] v_inc;
    logic [H_W-1:0]  h_new;
    logic [V_W-1:0]  v_new;
    logic [H_W-1:0]  h_cmp4;
    logic            v_eq;

    assign h_sum  = {1'b0, i_h} + (H_W+1)'(2);
    assign v_inc  = {1'b0, i_v} + LCNT_W'(1);
    assign h_cmp4 = {i_h_cmp, 2'b00};

    always_comb begin
        if (i_linear_mode) begin
            h_new = h_sum[H_W-1:0];
            v_new = i_v + V_W'(h_sum[H_W]);
        end else if (h_sum >= (H_W+1)'(LINE_CLOCKS)) begin
            h_new = '0;
            v_new = (v_inc >= i_line_count) ? '0 : v_inc[V_W-1:0];
        end else begin
            h_new = h_sum[H_W-1:0];
            v_new = i_v;
        end
    end

    assign v_eq = (v_new == i_v_cmp);

    always_comb begin
        o_tick.h = h_new;
        o_tick.v = v_new;
        case (i_cmp_en)
            CMPEN_H:  o_tick.hit = (h_new == h_cmp4);
            CMPEN_V:  o_tick.hit = v_eq && (h_new == '0);
            CMPEN_HV: o_tick.hit = v_eq && (h_new == h_cmp4);
            default:  o_tick.hit = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/hvtic_prio.sv
// Interrupt priority selection at an instruction boundary.
`default_nettype none
module hvtic_prio (
    input  wire logic                         i_masked,
    input  wire logic                         i_nmi,
    input  wire logic                         i_ext,
    input  wire logic [hvtic_pkg::FLAG_W-1:0] i_marks,
    input  wire logic [1:0]                   i_irq_en,
    input  wire logic [hvtic_pkg::VEC_W-1:0]  i_nmi_vec,
    input  wire logic [hvtic_pkg::VEC_W-1:0]  i_irq_vec,
    output hvtic_pkg::t_pick                  o_pick
);
    import hvtic_pkg::*;

    always_comb begin
        o_pick.take     = 1'b1;
        o_pick.flag     = FLAG_NONE;
        o_pick.vec      = i_irq_vec;
        o_pick.mark_set = FLAG_NONE;
        if (i_nmi && !(|(i_marks & FLAG_NMI))) begin
            o_pick.flag     = FLAG_NMI;
            o_pick.vec      = i_nmi_vec;
            o_pick.mark_set = FLAG_NMI;
        end else if (i_masked) begin
            o_pick.take = 1'b0;
        end else if (i_irq_en[IEN_TIMER] && !(|(i_marks & FLAG_TIMER))) begin
            o_pick.flag = FLAG_TIMER;
        end else if (i_irq_en[IEN_DMA] && !(|(i_marks & FLAG_DMA))) begin
            o_pick.flag = FLAG_DMA;
        end else if (i_ext && !(|(i_marks & FLAG_IRQ))) begin
            o_pick.flag = FLAG_IRQ;
        end else begin
            o_pick.take = 1'b0;
        end
    end

endmodule
`default_nettype wire

### rtl/hv_timer_interrupt_controller.sv
// Top level: input register, state update, result register.
//
// Channel   Dir  Ready/valid              Payload
// s_axis    in   i_s_tvalid/o_s_tready    tuser cmd, tdata masked/nmi/ext/clear_bits
// m_axis    out  o_m_tvalid/i_m_tready    tdata pending/vector/flags/h/v
// cfg       in   i_cfg_we                 i_cfg_addr, i_cfg_wdata
//
// One item per cycle sustained while the output is not stalled.
// The input register feeds one level of counter and priority logic into the result register.
// A stalled result holds; the input register still takes one more item.
// Reset clears the counters, flags, marks, pending bit and vector latch.
`default_nettype none
module hv_timer_interrupt_controller (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [hvtic_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [hvtic_pkg::CFG_DW-1:0]    i_cfg_wdata,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [0] irq_masked, [1] nmi_request, [2] ext_irq_request, [6:3] clear_bits
    input  wire logic [hvtic_pkg::IN_DW-1:0]     i_s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]                      i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [0] pending, [16:1] vector, [20:17] flags, [31:21] h_position, [40:32] v_position
    output logic [hvtic_pkg::OUT_DW-1:0]         o_m_tdata
);
    import hvtic_pkg::*;

    logic              r_linear_mode;
    logic [1:0]        r_cmp_en;
    logic [CMP_W-1:0]  r_h_cmp;
    logic [CMP_W-1:0]  r_v_cmp;
    logic [LCNT_W-1:0] r_line_count;
    logic [VEC_W-1:0]  r_nmi_vec;
    logic [VEC_W-1:0]  r_irq_vec;
    logic [1:0]        r_irq_en;

    logic              r_in_valid;
    t_cmd              r_in_cmd;
    logic              r_in_masked;
    logic              r_in_nmi;
    logic              r_in_ext;
    logic [FLAG_W-1:0] r_in_clear;

    logic [H_W-1:0]    r_h,     n_h;
    logic [V_W-1:0]    r_v,     n_v;
    logic [FLAG_W-1:0] r_flags, n_flags;
    logic [FLAG_W-1:0] r_marks, n_marks;
    logic              r_pend,  n_pend;
    logic [VEC_W-1:0]  r_vec,   n_vec;

    logic              r_out_valid;
    logic [OUT_DW-1:0] r_out_data;

    logic              advance;
    t_tick             tick;
    t_pick             pick;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear_mode <= 1'b0;
            r_cmp_en      <= '0;
            r_h_cmp       <= '0;
            r_v_cmp       <= '0;
            r_line_count  <= LINE_COUNT_RST;
            r_nmi_vec     <= '0;
            r_irq_vec     <= '0;
            r_irq_en      <= '0;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_addr))
                REG_LINEAR_MODE: r_linear_mode <= i_cfg_wdata[0];
                REG_CMP_EN:      r_cmp_en      <= i_cfg_wdata[1:0];
                REG_H_CMP:       r_h_cmp       <= i_cfg_wdata[CMP_W-1:0];
                REG_V_CMP:       r_v_cmp       <= i_cfg_wdata[CMP_W-1:0];
                REG_LINE_COUNT:  r_line_count  <= i_cfg_wdata[LCNT_W-1:0];
                REG_NMI_VECTOR:  r_nmi_vec     <= i_cfg_wdata;
                REG_IRQ_VECTOR:  r_irq_vec     <= i_cfg_wdata;
                REG_IRQ_EN:      r_irq_en      <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_cmd    <= t_cmd'(i_s_tuser);
            r_in_masked <= i_s_tdata[0];
            r_in_nmi    <= i_s_tdata[1];
            r_in_ext    <= i_s_tdata[2];
            r_in_clear  <= i_s_tdata[6:3];
        end
    end

    hvtic_tick u_tick (
        .i_linear_mode (r_linear_mode),
        .i_cmp_en      (r_cmp_en),
        .i_h_cmp       (r_h_cmp),
        .i_v_cmp       (r_v_cmp),
        .i_line_count  (r_line_count),
        .i_h           (r_h),
        .i_v           (r_v),
        .o_tick        (tick)
    );

    hvtic_prio u_prio (
        .i_masked  (r_in_masked),
        .i_nmi     (r_in_nmi),
        .i_ext     (r_in_ext),
        .i_marks   (r_marks),
        .i_irq_en  (r_irq_en),
        .i_nmi_vec (r_nmi_vec),
        .i_irq_vec (r_irq_vec),
        .o_pick    (pick)
    );

    always_comb begin
        n_h     = r_h;
        n_v     = r_v;
        n_flags = r_flags;
        n_marks = r_marks;
        n_pend  = r_pend;
        n_vec   = r_vec;
        case (r_in_cmd)
            CMD_TICK: begin
                n_h = tick.h;
                n_v = tick.v;
                if (tick.hit) begin
                    n_flags = r_flags | FLAG_TIMER;
                    if (r_irq_en[IEN_TIMER]) begin
                        n_marks = r_marks & ~FLAG_TIMER;
                    end
                end
            end
            CMD_BOUNDARY: begin
                if (pick.take) begin
                    n_pend  = 1'b1;
                    n_vec   = pick.vec;
                    n_flags = r_flags | pick.flag;
                    n_marks = r_marks | pick.mark_set;
                end
            end
            CMD_CLEAR: begin
                n_marks = r_in_clear;
                n_flags = r_flags & ~r_in_clear;
            end
            CMD_SERVICED: begin
                n_pend = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= '0;
            r_v     <= '0;
            r_flags <= '0;
            r_marks <= '0;
            r_pend  <= 1'b0;
            r_vec   <= '0;
        end else if (advance) begin
            r_h     <= n_h;
            r_v     <= n_v;
            r_flags <= n_flags;
            r_marks <= n_marks;
            r_pend  <= n_pend;
            r_vec   <= n_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {7'd0, n_v, n_h, n_flags, n_vec, n_pend};
        end
    end

endmodule
`default_nettype wire

### rtl/hvtic_checker.sv
// Port-level checks for the HV timer and interrupt controller, with bind.
`default_nettype none
module hvtic_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_tvalid,
    input wire logic                            o_s_tready,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [hvtic_pkg::OUT_DW-1:0]    o_m_tdata
);
    import hvtic_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_h_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[21])
        else $error("horizontal position odd");

    a_ready_after_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid && !$past(i_s_tvalid && o_s_tready) |-> o_s_tready)
        else $error("input stalled with empty pipeline");

endmodule

bind hv_timer_interrupt_controller hvtic_checker u_hvtic_checker (.*);
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for hv_timer_interrupt_controller.
`timescale 1ns / 1ps
module testbench;
    import hvtic_pkg::*;

    typedef struct packed {
        logic              linear;
        logic [1:0]        cmp_en;
        logic [CMP_W-1:0]  h_cmp;
        logic [CMP_W-1:0]  v_cmp;
        logic [LCNT_W-1:0] lines;
        logic [VEC_W-1:0]  nmi_vec;
        logic [VEC_W-1:0]  irq_vec;
        logic [1:0]        irq_en;
    } t_settings;

    typedef struct packed {
        logic              pending;
        logic [VEC_W-1:0]  vector;
        logic [FLAG_W-1:0] flags;
        logic [H_W-1:0]    h_pos;
        logic [V_W-1:0]    v_pos;
    } t_outcome;

    class hvtic_scoreboard;
        t_settings         cfg;
        logic [H_W-1:0]    h_cnt;
        logic [V_W-1:0]    v_cnt;
        logic [FLAG_W-1:0] status;
        logic [FLAG_W-1:0] marks;
        logic              pend;
        logic [VEC_W-1:0]  vec_latch;
        t_outcome          status_q[$];
        int                errors;
        int                seen;

        function new();
            cfg       = '0;
            cfg.lines = LINE_COUNT_RST;
            h_cnt     = '0;
            v_cnt     = '0;
            status    = FLAG_NONE;
            marks     = FLAG_NONE;
            pend      = 1'b0;
            vec_latch = '0;
            errors    = 0;
            seen      = 0;
        endfunction

        function void raise_timer();
            status |= FLAG_TIMER;
            if (cfg.irq_en[IEN_TIMER]) marks &= ~FLAG_TIMER;
        endfunction

        function void advance_counters();
            logic [H_W:0] h_next;
            logic [V_W:0] v_next;
            h_next = {1'b0, h_cnt} + (H_W+1)'(2);
            v_next = {1'b0, v_cnt};
            if (!cfg.linear) begin
                if (h_next >= LINE_CLOCKS) begin
                    h_next = '0;
                    v_next = v_next + (V_W+1)'(1);
                    if (v_next >= cfg.lines) v_next = '0;
                end
            end else begin
                v_next = v_next + h_next[H_W];
            end
            h_cnt = h_next[H_W-1:0];
            v_cnt = v_next[V_W-1:0];
            case (cfg.cmp_en)
                CMPEN_H: begin
                    if (h_cnt == {cfg.h_cmp, 2'b00}) raise_timer();
                end
                CMPEN_V: begin
                    if (v_cnt == cfg.v_cmp && h_cnt == '0) raise_timer();
                end
                CMPEN_HV: begin
                    if (v_cnt == cfg.v_cmp && h_cnt == {cfg.h_cmp, 2'b00}) raise_timer();
                end
                default: ;
            endcase
        endfunction

        function void take(logic [FLAG_W-1:0] flag, logic [VEC_W-1:0] vec);
            pend      = 1'b1;
            vec_latch = vec;
            status   |= flag;
        endfunction

        function void pick_interrupt(logic masked, logic nmi, logic ext);
            if (nmi && (marks & FLAG_NMI) == FLAG_NONE) begin
                take(FLAG_NMI, cfg.nmi_vec);
                marks |= FLAG_NMI;
            end else if (!masked) begin
                if (cfg.irq_en[IEN_TIMER] && (marks & FLAG_TIMER) == FLAG_NONE)
                    take(FLAG_TIMER, cfg.irq_vec);
                else if (cfg.irq_en[IEN_DMA] && (marks & FLAG_DMA) == FLAG_NONE)
                    take(FLAG_DMA, cfg.irq_vec);
                else if (ext && (marks & FLAG_IRQ) == FLAG_NONE)
                    take(FLAG_IRQ, cfg.irq_vec);
            end
        endfunction

        function void note_transfer(t_cmd cmd, logic [IN_DW-1:0] data);
            t_outcome next_status;
            case (cmd)
                CMD_TICK: advance_counters();
                CMD_BOUNDARY: pick_interrupt(data[0], data[1], data[2]);
                CMD_CLEAR: begin
                    marks   = data[6:3];
                    status &= ~data[6:3];
                end
                default: pend = 1'b0;
            endcase
            next_status.pending = pend;
            next_status.vector  = vec_latch;
            next_status.flags   = status;
            next_status.h_pos   = h_cnt;
            next_status.v_pos   = v_cnt;
            status_q.push_back(next_status);
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR at %0t: %s", $realtime, msg);
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %0h expected %0h", seen, name, got, want));
        endtask

        task check_status(logic [OUT_DW-1:0] data);
            t_outcome want;
            if (status_q.size() == 0) begin
                report($sformatf("result with nothing expected: %h", data));
                return;
            end
            want = status_q.pop_front();
            check_field("pending", 16'(data[0]), 16'(want.pending));
            check_field("vector", data[16:1], want.vector);
            check_field("flags", 16'(data[20:17]), 16'(want.flags));
            check_field("h_position", 16'(data[31:21]), 16'(want.h_pos));
            check_field("v_position", 16'(data[40:32]), 16'(want.v_pos));
            seen++;
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_addr;
    logic [CFG_DW-1:0]   i_cfg_wdata;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [IN_DW-1:0]    i_s_tdata;
    logic [1:0]          i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [OUT_DW-1:0]   o_m_tdata;

    hvtic_scoreboard board;
    bit s_idle;
    bit m_idle;

    hv_timer_interrupt_controller DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_status(o_m_tdata);
    end

    function automatic t_settings make_settings(logic linear, logic [1:0] cmp_en,
                                                logic [CMP_W-1:0] h_cmp, logic [CMP_W-1:0] v_cmp,
                                                logic [LCNT_W-1:0] lines,
                                                logic [VEC_W-1:0] nmi_vec,
                                                logic [VEC_W-1:0] irq_vec, logic [1:0] irq_en);
        t_settings s;
        s.linear  = linear;
        s.cmp_en  = cmp_en;
        s.h_cmp   = h_cmp;
        s.v_cmp   = v_cmp;
        s.lines   = lines;
        s.nmi_vec = nmi_vec;
        s.irq_vec = irq_vec;
        s.irq_en  = irq_en;
        return s;
    endfunction

    function automatic t_settings rand_settings();
        t_settings s;
        s.linear = ($urandom_range(0, 3) == 0);
        s.cmp_en = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1)
            s.h_cmp = 9'((board.h_cnt >> 2) + $urandom_range(1, 12));
        else
            s.h_cmp = 9'($urandom);
        s.v_cmp = ($urandom_range(0, 1) == 1) ? board.v_cnt : 9'($urandom);
        case ($urandom_range(0, 3))
            0: s.lines = LINE_COUNT_RST;
            1: s.lines = 10'd312;
            2: s.lines = 10'($urandom_range(0, 4));
            default: s.lines = 10'($urandom);
        endcase
        s.nmi_vec = 16'($urandom);
        s.irq_vec = 16'($urandom);
        s.irq_en  = 2'($urandom);
        return s;
    endfunction

    task automatic write_reg(t_reg idx, logic [CFG_DW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_config(t_settings s);
        write_reg(REG_LINEAR_MODE, CFG_DW'(s.linear));
        write_reg(REG_CMP_EN, CFG_DW'(s.cmp_en));
        write_reg(REG_H_CMP, CFG_DW'(s.h_cmp));
        write_reg(REG_V_CMP, CFG_DW'(s.v_cmp));
        write_reg(REG_LINE_COUNT, CFG_DW'(s.lines));
        write_reg(REG_NMI_VECTOR, s.nmi_vec);
        write_reg(REG_IRQ_VECTOR, s.irq_vec);
        write_reg(REG_IRQ_EN, CFG_DW'(s.irq_en));
        i_cfg_we  <= 1'b0;
        board.cfg  = s;
    endtask

    task automatic send_item(t_cmd cmd, logic masked, logic nmi, logic ext, logic [3:0] clr);
        int               gap;
        logic [IN_DW-1:0] payload;
        gap     = s_idle ? $urandom_range(0, 12) : 0;
        payload = {1'b0, clr, ext, nmi, masked};
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= payload;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_transfer(cmd, payload);
    endtask

    task automatic tick_run(int count);
        repeat (count) send_item(CMD_TICK, 1'b0, 1'b0, 1'b0, 4'h0);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (board.status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_run(int count);
        int         pick;
        t_cmd       cmd;
        logic [3:0] clr;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            cmd  = (pick < 40) ? CMD_TICK : (pick < 70) ? CMD_BOUNDARY :
                   (pick < 85) ? CMD_CLEAR : CMD_SERVICED;
            clr  = ($urandom_range(0, 1) == 1) ? 4'($urandom) : 4'h0;
            send_item(cmd, ($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), clr);
        end
    endtask

    initial begin
        int w;
        i_m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            w = m_idle ? $urandom_range(0, 12) : 0;
            if (w > 0) begin
                i_m_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    initial begin
        t_settings s;
        board = new();
        s_idle = 1'b1;
        m_idle = 1'b1;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= REG_LINEAR_MODE;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= CMD_TICK;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // priority and masking
        apply_config(make_settings(1'b0, CMPEN_OFF, 9'd0, 9'd0, LINE_COUNT_RST,
                                   16'hffff, 16'h0000, 2'b00));
        send_item(CMD_BOUNDARY, 1'b0, 1'b0, 1'b0, 4'h0);
        send_item(CMD_BOUNDARY, 1'b1, 1'b0, 1'b1, 4'h0);
        send_item(CMD_BOUNDARY, 1'b0, 1'b0, 1'b1, 4'h0);
        send_item(CMD_SERVICED, 1'b1, 1'b1, 1'b1, 4'hf);
        send_item(CMD_BOUNDARY, 1'b1, 1'b1, 1'b0, 4'h0);
        send_item(CMD_BOUNDARY, 1'b0, 1'b1, 1'b1, 4'h0);
        send_item(CMD_CLEAR, 1'b0, 1'b0, 1'b0, 4'hf);
        send_item(CMD_BOUNDARY, 1'b0, 1'b1, 1'b1, 4'h0);
        send_item(CMD_CLEAR, 1'b0, 1'b0, 1'b0, 4'h0);
        drain();

        // timer, DMA and external request taken while their marks are clear
        apply_config(make_settings(1'b0, CMPEN_OFF, 9'd0, 9'd0, LINE_COUNT_RST,
                                   16'h0000, 16'hffff, 2'b11));
        send_item(CMD_BOUNDARY, 1'b0, 1'b0, 1'b0, 4'h0);
        send_item(CMD_CLEAR, 1'b0, 1'b0, 1'b0, 4'b0010);
        send_item(CMD_BOUNDARY, 1'b0, 1'b0, 1'b1, 4'h0);
        send_item(CMD_CLEAR, 1'b0, 1'b0, 1'b0, 4'b0110);
        send_item(CMD_BOUNDARY, 1'b0, 1'b0, 1'b1, 4'h0);
        send_item(CMD_BOUNDARY, 1'b1, 1'b1, 1'b0, 4'h0);
        send_item(CMD_SERVICED, 1'b0, 1'b0, 1'b0, 4'h0);
        drain();

        // horizontal compare arms the timer
        apply_config(make_settings(1'b0, CMPEN_H, 9'd1, 9'd0, LINE_COUNT_RST,
                                   16'h1234, 16'hffff, 2'b01));
        send_item(CMD_CLEAR, 1'b0, 1'b0, 1'b0, 4'hf);
        tick_run(3);
        send_item(CMD_BOUNDARY, 1'b0, 1'b0, 1'b0, 4'h0);
        drain();

        // combined compare
        apply_config(make_settings(1'b0, CMPEN_HV, 9'd3, 9'd0, LINE_COUNT_RST,
                                   16'h1234, 16'h8001, 2'b01));
        send_item(CMD_CLEAR, 1'b0, 1'b0, 1'b0, 4'hf);
        tick_run(4);
        send_item(CMD_BOUNDARY, 1'b0, 1'b0, 1'b0, 4'h0);
        drain();

        // tick run, back to back
        s_idle = 1'b0;
        m_idle = 1'b0;
        apply_config(make_settings(1'b0, CMPEN_H, 9'd20, 9'd0, LINE_COUNT_RST,
                                   16'h0000, 16'h5a5a, 2'b01));
        tick_run(60);
        drain();

        // corner and random settings, random traffic
        for (int p = 0; p < 10; p++) begin
            s_idle = ($urandom_range(0, 3) != 0);
            m_idle = ($urandom_range(0, 3) != 0);
            if (p == 0)
                s = make_settings(1'b1, CMPEN_HV, 9'd511, 9'd511, 10'd1023,
                                  16'hffff, 16'hffff, 2'b11);
            else if (p == 1)
                s = make_settings(1'b0, CMPEN_OFF, 9'd0, 9'd0, 10'd0,
                                  16'h0000, 16'h0000, 2'b00);
            else
                s = rand_settings();
            apply_config(s);
            random_run(56);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.status_q.size() == 0) begin
            $display("PASS hv_timer_interrupt_controller");
        end else begin
            $display("FAIL hv_timer_interrupt_controller");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("FAIL hv_timer_interrupt_controller");
        $finish;
    end

endmodule
